[hw/rtl/psc_pkg.sv]
// Shared types, constants and helpers for the peak step counter.
// No dependencies; psc_thresh and peak_step_counter_core import this package.
`default_nettype none

package psc_pkg;

   localparam int RATE_W     = 16;
   localparam int MAG_W      = RATE_W + 1;
   localparam int STEP_W     = 16;
   localparam int MAG_MAX    = 98304;
   localparam int WINDOW_DEF = 100;

   localparam logic [MAG_W-1:0] MIN_THRESHOLD_RESET = MAG_W'(1000);

   // exact divide by ten of a value below 2**TEN_IN_W: (x * TEN_DIV_M) >> TEN_DIV_K
   localparam int TEN_IN_W   = 20;
   localparam int TEN_DIV_K  = 24;
   localparam int TEN_M_W    = 21;
   localparam logic [TEN_M_W-1:0] TEN_DIV_M = TEN_M_W'(1677722);
   localparam int TEN_PROD_W = TEN_IN_W + TEN_M_W;

   typedef struct packed {
      logic signed [RATE_W-1:0] rate_x;
      logic signed [RATE_W-1:0] rate_y;
      logic signed [RATE_W-1:0] rate_z;
   } req_type;

   typedef struct packed {
      logic [STEP_W-1:0] step_total;
      logic              step_seen;
      logic [MAG_W-1:0]  active_threshold;
   } rsp_type;

   typedef struct packed {
      logic             valid;
      logic             peak;
      logic [MAG_W-1:0] peak_val;
   } psc_ctl_type;

   function automatic int sum_width(input int window);
      return $clog2(window * MAG_MAX + 1);
   endfunction

endpackage

`default_nettype wire

[hw/rtl/psc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
`default_nettype none

module psc_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 100
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

[hw/rtl/psc_thresh.sv]
// Threshold pipeline: peak sum divided by the window, then scaled by nine tenths.
// Two register stages, one constant multiplication each; depends on psc_pkg.
`default_nettype none

module psc_thresh #(
   parameter int WINDOW = psc_pkg::WINDOW_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  advance,
   input  wire psc_pkg::psc_ctl_type                  ctl_i,
   input  wire logic [psc_pkg::sum_width(WINDOW)-1:0] sum_i,
   output      psc_pkg::psc_ctl_type                  ctl_o,
   output      logic [psc_pkg::MAG_W-1:0]             quot_o
);

   import psc_pkg::*;

   localparam int SUM_W   = sum_width(WINDOW);
   localparam int DIV_L   = $clog2(WINDOW);
   localparam int DIV_K   = SUM_W + DIV_L;
   localparam longint unsigned DIV_M = ((64'd1 << DIV_K) + WINDOW - 1) / WINDOW;
   localparam int DIV_M_W = $clog2(DIV_M + 1);
   localparam int PROD_W  = SUM_W + DIV_M_W;
   localparam logic [DIV_M_W-1:0] DIV_M_C = DIV_M_W'(DIV_M);

   psc_ctl_type             a_ctl_ff;
   logic [PROD_W-1:0]       a_prod_ff;
   logic [PROD_W-1:0]       a_prod_in;
   psc_ctl_type             b_ctl_ff;
   logic [TEN_PROD_W-1:0]   b_prod_ff;
   logic [TEN_PROD_W-1:0]   b_prod_in;
   logic [MAG_W-1:0]        avg;
   logic [TEN_IN_W-1:0]     avg_x9;

   always_comb begin
      a_prod_in = PROD_W'(sum_i) * PROD_W'(DIV_M_C);
      avg       = a_prod_ff[DIV_K +: MAG_W];
      avg_x9    = TEN_IN_W'({avg, 3'b000}) + TEN_IN_W'(avg);
      b_prod_in = TEN_PROD_W'(avg_x9) * TEN_PROD_W'(TEN_DIV_M);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctl_ff.valid <= 1'b0;
         b_ctl_ff.valid <= 1'b0;
      end else if (advance) begin
         a_ctl_ff.valid <= ctl_i.valid;
         b_ctl_ff.valid <= a_ctl_ff.valid;
      end
      if (advance) begin
         a_ctl_ff.peak     <= ctl_i.peak;
         a_ctl_ff.peak_val <= ctl_i.peak_val;
         a_prod_ff         <= a_prod_in;
         b_ctl_ff.peak     <= a_ctl_ff.peak;
         b_ctl_ff.peak_val <= a_ctl_ff.peak_val;
         b_prod_ff         <= b_prod_in;
      end
   end

   assign ctl_o  = b_ctl_ff;
   assign quot_o = b_prod_ff[TEN_DIV_K +: MAG_W];

endmodule

`default_nettype wire

[hw/rtl/peak_step_counter_core.sv]
// Peak step counter: magnitude, peak ring with running sum, adaptive threshold.
// Reset clears valids, step count, ring position, sum and fill bits; sets thresholds.
// Throughput: one item per cycle; input stalls only while the output skid entry is full.
// Ring entries read as zero until written (per-entry valid bits).
// Depends on psc_pkg, psc_ram and psc_thresh.
`default_nettype none

module peak_step_counter_core #(
   parameter int WINDOW = psc_pkg::WINDOW_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output      logic                      req_stall,
   input  wire psc_pkg::req_type          req_data,
   output      logic                      rsp_valid,
   input  wire logic                      rsp_stall,
   output      psc_pkg::rsp_type          rsp_data,
   input  wire logic                      csr_valid,
   output      logic                      csr_ready,
   input  wire logic [psc_pkg::MAG_W-1:0] csr_data
);

   import psc_pkg::*;

   localparam int SUM_W = sum_width(WINDOW);
   localparam int POS_W = $clog2(WINDOW);
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW - 1);

   function automatic logic [MAG_W-1:0] rate_abs(input logic signed [RATE_W-1:0] rate);
      logic [MAG_W-1:0] ext;
      ext = {rate[RATE_W-1], rate};
      return rate[RATE_W-1] ? (MAG_W'(0) - ext) : ext;
   endfunction

   logic              adv;
   logic              in_vld_ff;
   req_type           in_data_ff;
   logic [MAG_W-1:0]  mag;
   logic              is_peak;
   logic              st1_go;
   logic              st1_peak;
   logic [MAG_W-1:0]  prior_ff;
   logic [POS_W-1:0]  pos_ff;
   logic [POS_W-1:0]  pos_nx;
   logic [POS_W-1:0]  pos_in;
   logic [POS_W-1:0]  rd_addr;
   logic [SUM_W-1:0]  sum_ff;
   logic [SUM_W-1:0]  sum_nx;
   logic [WINDOW-1:0] fill_ff;
   logic              rd_fill_ff;
   logic [MAG_W-1:0]  rd_data;
   logic [MAG_W-1:0]  old_peak;
   psc_ctl_type       ctl1_in;
   psc_ctl_type       ctl1_ff;
   logic [SUM_W-1:0]  sum1_ff;
   psc_ctl_type       b_ctl;
   logic [MAG_W-1:0]  b_quot;
   logic [MAG_W-1:0]  min_ff;
   logic [MAG_W-1:0]  thr_ff;
   logic [MAG_W-1:0]  thr_in;
   logic [MAG_W-1:0]  thr_calc;
   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   logic [STEP_W-1:0] step_nx;
   logic              fin_push;
   logic              fin_seen;
   rsp_type           fin_res;
   logic              take;
   logic              rsp_vld_ff;
   logic              rsp_vld_in;
   rsp_type           rsp_ff;
   rsp_type           rsp_in;
   logic              skid_vld_ff;
   logic              skid_vld_in;
   rsp_type           skid_ff;
   rsp_type           skid_in;

   assign adv       = ~skid_vld_ff;
   assign req_stall = skid_vld_ff;
   assign csr_ready = 1'b1;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (adv) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         in_data_ff <= req_data;
      end
   end

   // magnitude, peak detect, ring and running sum
   always_comb begin
      mag      = rate_abs(in_data_ff.rate_x) + rate_abs(in_data_ff.rate_y)
               + rate_abs(in_data_ff.rate_z);
      is_peak  = prior_ff > mag;
      st1_go   = adv & in_vld_ff;
      st1_peak = st1_go & is_peak;
      old_peak = rd_fill_ff ? rd_data : '0;
      pos_nx   = (pos_ff == POS_LAST) ? '0 : pos_ff + 1'b1;
      sum_nx   = sum_ff - SUM_W'(old_peak) + SUM_W'(prior_ff);
      pos_in   = st1_peak ? pos_nx : pos_ff;
      rd_addr  = (pos_in == POS_LAST) ? '0 : pos_in + 1'b1;
      ctl1_in.valid    = in_vld_ff;
      ctl1_in.peak     = is_peak;
      ctl1_in.peak_val = prior_ff;
   end

   psc_ram #(
      .WIDTH (MAG_W),
      .DEPTH (WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (st1_peak),
      .wr_addr (pos_nx),
      .wr_data (prior_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         prior_ff   <= '0;
         pos_ff     <= '0;
         sum_ff     <= '0;
         fill_ff    <= '0;
         rd_fill_ff <= 1'b0;
      end else begin
         rd_fill_ff <= fill_ff[rd_addr];
         if (st1_go) begin
            prior_ff <= mag;
         end
         if (st1_peak) begin
            pos_ff          <= pos_nx;
            sum_ff          <= sum_nx;
            fill_ff[pos_nx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff.valid <= 1'b0;
      end else if (adv) begin
         ctl1_ff.valid <= ctl1_in.valid;
      end
      if (adv) begin
         ctl1_ff.peak     <= ctl1_in.peak;
         ctl1_ff.peak_val <= ctl1_in.peak_val;
         sum1_ff          <= sum_nx;
      end
   end

   psc_thresh #(
      .WINDOW (WINDOW)
   ) u_thresh (
      .clock   (clock),
      .reset   (reset),
      .advance (adv),
      .ctl_i   (ctl1_ff),
      .sum_i   (sum1_ff),
      .ctl_o   (b_ctl),
      .quot_o  (b_quot)
   );

   // threshold floor, step decision, result
   always_comb begin
      fin_push = adv & b_ctl.valid;
      thr_calc = (b_quot < min_ff) ? min_ff : b_quot;
      fin_seen = b_ctl.peak & (b_ctl.peak_val > thr_calc);
      step_nx  = step_ff + STEP_W'(fin_seen);
      step_in  = fin_push ? step_nx : step_ff;
      thr_in   = (fin_push && b_ctl.peak) ? thr_calc : thr_ff;
      fin_res.step_total       = step_nx;
      fin_res.step_seen        = fin_seen;
      fin_res.active_threshold = b_ctl.peak ? thr_calc : thr_ff;
   end

   // output register with skid entry
   always_comb begin
      take        = rsp_vld_ff & ~rsp_stall;
      rsp_vld_in  = rsp_vld_ff;
      rsp_in      = rsp_ff;
      skid_vld_in = skid_vld_ff;
      skid_in     = skid_ff;
      if (skid_vld_ff) begin
         if (take) begin
            rsp_in      = skid_ff;
            skid_vld_in = 1'b0;
         end
      end else if (fin_push) begin
         if (!rsp_vld_ff || take) begin
            rsp_in     = fin_res;
            rsp_vld_in = 1'b1;
         end else begin
            skid_in     = fin_res;
            skid_vld_in = 1'b1;
         end
      end else if (take) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff      <= MIN_THRESHOLD_RESET;
         thr_ff      <= MIN_THRESHOLD_RESET;
         step_ff     <= '0;
         rsp_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            min_ff <= csr_data;
         end
         thr_ff      <= thr_in;
         step_ff     <= step_in;
         rsp_vld_ff  <= rsp_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   a_skid_needs_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> rsp_vld_ff)
      else $error("skid entry holds an item while output register is empty");

   a_pos_only_on_peak: assert property (@(posedge clock) disable iff (reset)
      !st1_peak |=> $stable(pos_ff))
      else $error("ring position moved without a peak");

   a_step_only_on_seen: assert property (@(posedge clock) disable iff (reset)
      !(fin_push && fin_seen) |=> $stable(step_ff))
      else $error("step count moved without a confirmed step");

   a_thr_only_on_peak: assert property (@(posedge clock) disable iff (reset)
      !(fin_push && b_ctl.peak) |=> $stable(thr_ff))
      else $error("threshold moved without a peak");

endmodule

`default_nettype wire
